// ----- hw/rtl/rs_gf256_systematic_encoder_core_defines.svh -----
// assertion macros shared by the reed-solomon encoder rtl
`ifndef RS_GF256_SYSTEMATIC_ENCODER_CORE_DEFINES_SVH
`define RS_GF256_SYSTEMATIC_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RSENC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RSENC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/rsenc_pkg.sv -----
// types, constants and gf(2^8) helpers for the reed-solomon encoder
`default_nettype none

package rsenc_pkg;

  localparam int MaxParity = 64;
  localparam int MinParity = 16;
  localparam int FieldN    = 255;
  localparam logic [8:0] GfPoly = 9'h11d;

  // parity mode register codes
  localparam logic [1:0] ModeP16 = 2'd0;
  localparam logic [1:0] ModeP32 = 2'd1;

  typedef logic [7:0] sym_t;
  typedef logic [1:0] mode_t;
  typedef logic [7:0] count_t;
  typedef logic [$clog2(MaxParity+1)-1:0] pcount_t;
  typedef logic [$clog2(MaxParity)-1:0] pop_idx_t;
  typedef logic [MaxParity:0][7:0] gen_t;
  typedef logic [MaxParity-1:0][7:0] lane_t;

  // channel payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       parity_last;
    logic       too_long;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic div_en;
    logic fill;
    logic set_ovf;
    logic pop;
    logic clear;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic below_limit;
    logic pop_last;
  } dp_status_t;

  // gf(2^8) multiply, shift-and-add over the field polynomial
  function automatic sym_t gf_mul(sym_t a, sym_t b);
    sym_t r;
    sym_t x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? GfPoly[7:0] : 8'h00);
    end
    return r;
  endfunction

  function automatic int clamp_parity(int p);
    return (p > MaxParity) ? MaxParity : p;
  endfunction

  // generator product of (x + alpha^i), i = 1..p; entry k is coefficient of x^k
  function automatic gen_t build_gen(int p);
    gen_t g;
    sym_t root;
    g    = '0;
    g[0] = 8'd1;
    root = 8'd1;
    for (int i = 1; i <= p; i++) begin
      root = gf_mul(root, 8'd2);
      for (int k = i; k >= 1; k--) begin
        g[k] = g[k-1] ^ gf_mul(g[k], root);
      end
      g[0] = gf_mul(g[0], root);
    end
    return g;
  endfunction

  // coefficient that each remainder lane multiplies the feedback by
  function automatic lane_t lane_coefs(int p);
    lane_t l;
    gen_t  g;
    l = '0;
    g = build_gen(p);
    for (int j = 0; j < MaxParity; j++) begin
      if (j < p) l[j] = g[p-1-j];
    end
    return l;
  endfunction

  localparam int P16 = clamp_parity(16);
  localparam int P32 = clamp_parity(32);
  localparam int P64 = clamp_parity(64);

  localparam lane_t Lane16 = lane_coefs(P16);
  localparam lane_t Lane32 = lane_coefs(P32);
  localparam lane_t Lane64 = lane_coefs(P64);

  // parity byte count for a mode; the unused code acts as the largest
  function automatic pcount_t parity_count(mode_t mode);
    pcount_t p;
    case (mode)
      ModeP16: p = pcount_t'(P16);
      ModeP32: p = pcount_t'(P32);
      default: p = pcount_t'(P64);
    endcase
    return p;
  endfunction

  // number of symbols divided before the parity is taken
  function automatic count_t symbol_limit(pcount_t p);
    return count_t'(FieldN - int'(p));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rsenc_dp.sv -----
// remainder register, gf multiplier lanes, counters and output payload register
`default_nettype none
`include "rs_gf256_systematic_encoder_core_defines.svh"

module rsenc_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rsenc_pkg::mode_t    mode,
  input  wire rsenc_pkg::sym_t     in_sym,
  input  wire rsenc_pkg::dp_cmd_t  cmd,
  output rsenc_pkg::dp_status_t    status,
  output rsenc_pkg::out_item_t     out_data
);

  rsenc_pkg::lane_t    rem;
  rsenc_pkg::lane_t    rem_next;
  rsenc_pkg::lane_t    rem_up;
  rsenc_pkg::count_t   symbol_count;
  rsenc_pkg::count_t   symbol_count_next;
  logic                overflow_seen;
  logic                overflow_seen_next;
  rsenc_pkg::pop_idx_t pop_count;
  rsenc_pkg::pop_idx_t pop_count_next;
  rsenc_pkg::pcount_t  pcount;
  rsenc_pkg::sym_t     fb;

  assign pcount = rsenc_pkg::parity_count(mode);
  assign rem_up = {8'h00, rem[rsenc_pkg::MaxParity-1:1]};

  // status back to the controller
  assign status.below_limit = (symbol_count < rsenc_pkg::symbol_limit(pcount));
  assign status.pop_last    = (pop_count == rsenc_pkg::pop_idx_t'(pcount - 1'b1));

  // remainder update: divide step, parity shift-out or clear
  always_comb begin
    rsenc_pkg::sym_t coef;
    rsenc_pkg::sym_t tail;
    coef     = '0;
    tail     = '0;
    fb       = (cmd.fill ? 8'h00 : in_sym) ^ rem[0];
    rem_next = rem;
    if (cmd.clear) begin
      rem_next = '0;
    end else if (cmd.pop) begin
      rem_next = rem_up;
    end else if (cmd.div_en) begin
      for (int j = 0; j < rsenc_pkg::MaxParity; j++) begin
        if (j < int'(pcount)) begin
          case (mode)
            rsenc_pkg::ModeP16: coef = rsenc_pkg::Lane16[j];
            rsenc_pkg::ModeP32: coef = rsenc_pkg::Lane32[j];
            default:            coef = rsenc_pkg::Lane64[j];
          endcase
          tail        = (j + 1 < int'(pcount)) ? rem_up[j] : 8'h00;
          rem_next[j] = tail ^ rsenc_pkg::gf_mul(fb, coef);
        end
      end
    end
  end

  // symbol, overflow and pop counters
  always_comb begin
    symbol_count_next  = symbol_count;
    overflow_seen_next = overflow_seen;
    pop_count_next     = pop_count;
    if (cmd.clear) begin
      symbol_count_next  = '0;
      overflow_seen_next = 1'b0;
      pop_count_next     = '0;
    end else begin
      if (cmd.div_en)  symbol_count_next  = symbol_count + 1'b1;
      if (cmd.set_ovf) overflow_seen_next = 1'b1;
      if (cmd.pop)     pop_count_next     = pop_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem           <= '0;
      symbol_count  <= '0;
      overflow_seen <= 1'b0;
      pop_count     <= '0;
    end else begin
      rem           <= rem_next;
      symbol_count  <= symbol_count_next;
      overflow_seen <= overflow_seen_next;
      pop_count     <= pop_count_next;
    end
  end

  // output payload register, loaded on each pop
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_data.parity_byte <= rem[0];
      out_data.parity_last <= status.pop_last;
      out_data.too_long    <= overflow_seen;
    end
  end

  `RSENC_ASSERT_NEXT(a_clear_resets_counts, clk, rst, cmd.clear, (symbol_count == '0) && !overflow_seen && (pop_count == '0), "clear left counters set")
  `RSENC_ASSERT_IMPLY(a_count_bounded, clk, rst, 1'b1, symbol_count <= rsenc_pkg::count_t'(rsenc_pkg::FieldN - rsenc_pkg::MinParity), "symbol count ran past the longest message")

endmodule

`default_nettype wire

// ----- hw/rtl/rsenc_ctrl.sv -----
// controller: accepts message bytes, runs the zero fill and sequences parity output
`default_nettype none
`include "rs_gf256_systematic_encoder_core_defines.svh"

module rsenc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_last,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire rsenc_pkg::dp_status_t  status,
  output rsenc_pkg::dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'b001,
    ST_FILL   = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_valid_next;

  assign in_stall = (state != ST_ACCEPT);
  assign out_free = !out_valid || !out_stall;

  // next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_ACCEPT: begin
        if (in_valid) begin
          if (status.below_limit) cmd.div_en  = 1'b1;
          else                    cmd.set_ovf = 1'b1;
          if (in_last) state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (status.below_limit) begin
          cmd.div_en = 1'b1;
          cmd.fill   = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.pop = 1'b1;
          if (status.pop_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_ACCEPT;
          end
        end
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  // output valid: set on pop, dropped once the transaction is taken
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.pop) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `RSENC_ASSERT_NEXT(a_pop_shows_result, clk, rst, cmd.pop, out_valid, "popped parity byte not presented")
  `RSENC_ASSERT_IMPLY(a_no_divide_while_pop, clk, rst, cmd.pop, !cmd.div_en && !cmd.set_ovf, "divide issued during parity output")

endmodule

`default_nettype wire

// ----- hw/rtl/rs_gf256_systematic_encoder_core.sv -----
// Systematic Reed-Solomon encoder over GF(2^8), polynomial 0x11d, generator
// roots alpha^1..alpha^P, with P = 16, 32 or 64 parity bytes set by cfg_wdata
// (0, 1, 2; code 3 acts as 64), written through cfg_we. The user must see to it
// that it is written only while the block is idle; the block itself does not
// enforce this. Input channel (in_valid / in_stall / in_data): one message byte
// per transaction, one per cycle while a message streams in; last_byte ends it.
// After the last byte the block divides zero symbols until 255 - P symbols are
// in, one per cycle, then switches over and shows P parity bytes on the output
// channel (out_valid / out_stall / out_data), highest order first, one per cycle
// when not stalled; parity_last marks the final one.
// in_stall is high from the last byte until the final parity byte has been
// loaded into the output register; a stall on the output holds the byte and
// pauses the parity sequence. Bytes beyond 255 - P are taken but not divided
// and too_long is set on every parity byte of that run.
// Reset (rst, synchronous) clears the remainder, counters, mode and out_valid;
// there is no clearing pass.
`default_nettype none

module rs_gf256_systematic_encoder_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire rsenc_pkg::mode_t     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rsenc_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rsenc_pkg::out_item_t      out_data
);

  rsenc_pkg::mode_t      parity_mode;
  rsenc_pkg::dp_cmd_t    cmd;
  rsenc_pkg::dp_status_t status;

  // parity mode configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      parity_mode <= rsenc_pkg::ModeP16;
    end else if (cfg_we) begin
      parity_mode <= cfg_wdata;
    end
  end

  rsenc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_byte),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rsenc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .mode     (parity_mode),
    .in_sym   (in_data.data_byte),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- dv/rs_gf256_systematic_encoder_core_tb.sv -----
// self-checking testbench for the gf(2^8) reed-solomon parity encoder
`default_nettype none

module rs_gf256_systematic_encoder_core_tb;
  import rsenc_pkg::*;

  // parity mode codes beyond the two the package names
  localparam mode_t ModeP64   = 2'd2;
  localparam mode_t ModeSpare = 2'd3;
  // low byte of the field polynomial, folded in when a product overflows
  localparam sym_t FieldLow = 8'h1d;
  // used as the settle time; longer than a whole run without stalls
  localparam int DrainCycles = 260;

  // directed stimulus row; exp_byte is the parity typed in when chk is set
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       wr;
    logic [1:0] mode;
    logic       chk;
    logic [7:0] exp_byte;
  } stim_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  mode_t     cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // encoder model state
  sym_t      rem_reg [0:MaxParity-1];
  sym_t      gen_tab [0:MaxParity];
  int        gen_len = 0;
  int        fed_count = 0;
  bit        overflowed = 1'b0;
  mode_t     cur_mode = ModeP16;

  out_item_t parity_q [$];
  out_item_t want_item;
  int        errors = 0;
  bit        idle_en = 1'b1;
  int        stall_left = 0;
  int        quiet_left = 0;

  // zero messages give zero parity in every mode
  stim_row_t directed_tab [18] = '{
    '{8'h00, 1'b1, 1'b1, ModeP16,   1'b1, 8'h00},
    '{8'hff, 1'b1, 1'b0, ModeP16,   1'b0, 8'h00},
    '{8'h01, 1'b0, 1'b0, ModeP16,   1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, ModeP16,   1'b0, 8'h00},
    '{8'hff, 1'b1, 1'b0, ModeP16,   1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, ModeP32,   1'b1, 8'h00},
    '{8'h00, 1'b0, 1'b0, ModeP32,   1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, ModeP32,   1'b1, 8'h00},
    '{8'ha5, 1'b0, 1'b0, ModeP32,   1'b0, 8'h00},
    '{8'h5a, 1'b1, 1'b0, ModeP32,   1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, ModeP64,   1'b1, 8'h00},
    '{8'hff, 1'b0, 1'b0, ModeP64,   1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, ModeP64,   1'b0, 8'h00},
    '{8'h7f, 1'b1, 1'b0, ModeP64,   1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, ModeSpare, 1'b1, 8'h00},
    '{8'h12, 1'b0, 1'b0, ModeSpare, 1'b0, 8'h00},
    '{8'h34, 1'b1, 1'b0, ModeSpare, 1'b0, 8'h00},
    '{8'hff, 1'b1, 1'b1, ModeP16,   1'b0, 8'h00}
  };

  rs_gf256_systematic_encoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gf(2^8) product: add shifted copies of a for each set bit of b
  function automatic sym_t gf_times(sym_t a, sym_t b);
    sym_t acc;
    sym_t sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ sh;
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? FieldLow : 8'h00);
    end
    return acc;
  endfunction

  function automatic int check_byte_count(mode_t m);
    case (m)
      ModeP16: return 16;
      ModeP32: return 32;
      default: return 64;
    endcase
  endfunction

  // generator coefficients for p roots alpha^1..alpha^p, index = power of x
  task automatic load_generator(int p);
    sym_t root;
    if (gen_len == p) return;
    for (int k = 0; k <= MaxParity; k++) gen_tab[k] = '0;
    gen_tab[0] = 8'h01;
    root = 8'h01;
    for (int i = 1; i <= p; i++) begin
      root = gf_times(root, 8'h02);
      for (int k = i; k >= 1; k--) gen_tab[k] = gen_tab[k-1] ^ gf_times(gen_tab[k], root);
      gen_tab[0] = gf_times(gen_tab[0], root);
    end
    gen_len = p;
  endtask

  // one lfsr step of the remainder register
  task automatic divide_in(sym_t s, int p);
    sym_t fb;
    fb = s ^ rem_reg[0];
    for (int j = 0; j + 1 < p; j++) rem_reg[j] = rem_reg[j+1] ^ gf_times(fb, gen_tab[p-1-j]);
    rem_reg[p-1] = gf_times(fb, gen_tab[0]);
  endtask

  // update the encoder model for one accepted byte; queue parity on the last one
  task automatic encode_byte(in_item_t it, bit typed, sym_t typed_byte);
    int        p;
    int        lim;
    out_item_t r;
    p   = check_byte_count(cur_mode);
    lim = 255 - p;
    load_generator(p);
    if (fed_count < lim) begin
      divide_in(it.data_byte, p);
      fed_count++;
    end else begin
      overflowed = 1'b1;
    end
    if (it.last_byte) begin
      // shortening zeros, then the parity, highest order first
      while (fed_count < lim) begin
        divide_in(8'h00, p);
        fed_count++;
      end
      for (int k = 0; k < p; k++) begin
        r.parity_byte = typed ? typed_byte : rem_reg[k];
        r.parity_last = (k == p - 1);
        r.too_long    = typed ? 1'b0 : overflowed;
        parity_q.push_back(r);
      end
      for (int k = 0; k < MaxParity; k++) rem_reg[k] = '0;
      fed_count  = 0;
      overflowed = 1'b0;
    end
  endtask

  // present one byte, with an optional gap first, and hold it until taken
  task automatic send_byte(in_item_t it, bit typed, sym_t typed_byte);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    encode_byte(it, typed, typed_byte);
  endtask

  // random message of n bytes, extremes mixed in
  task automatic send_message(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0:       it.data_byte = 8'h00;
        1:       it.data_byte = 8'hff;
        default: it.data_byte = sym_t'($urandom_range(0, 255));
      endcase
      it.last_byte = (i == n - 1);
      send_byte(it, 1'b0, 8'h00);
    end
  endtask

  // stop sending and wait for every queued parity byte plus a full run
  task automatic settle();
    in_valid <= 1'b0;
    while (parity_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = m;
  endtask

  // receiver stalls in bursts, with quiet stretches between
  always @(posedge clk) begin
    if (!idle_en) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(20, 60);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each output transaction with the oldest queued parity byte
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (parity_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected parity byte %h last %b too_long %b", $time,
                 out_data.parity_byte, out_data.parity_last, out_data.too_long);
      end else begin
        want_item = parity_q.pop_front();
        if (out_data.parity_byte !== want_item.parity_byte) begin
          errors++;
          $display("%0t: parity_byte expected %h actual %h", $time,
                   want_item.parity_byte, out_data.parity_byte);
        end
        if (out_data.parity_last !== want_item.parity_last) begin
          errors++;
          $display("%0t: parity_last expected %b actual %b", $time,
                   want_item.parity_last, out_data.parity_last);
        end
        if (out_data.too_long !== want_item.too_long) begin
          errors++;
          $display("%0t: too_long expected %b actual %b", $time,
                   want_item.too_long, out_data.too_long);
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    in_item_t it;
    int       sent;
    int       n;
    mode_t    phase_modes [6];

    phase_modes = '{ModeP32, ModeP64, ModeP16, ModeSpare, ModeP64, ModeP16};
    for (int k = 0; k < MaxParity; k++) rem_reg[k] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < $size(directed_tab); i++) begin
      if (directed_tab[i].wr) write_mode(mode_t'(directed_tab[i].mode));
      it.data_byte = directed_tab[i].data;
      it.last_byte = directed_tab[i].last;
      send_byte(it, directed_tab[i].chk, directed_tab[i].exp_byte);
    end

    // random messages, mostly short, across all modes
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(phase_modes[ph]);
      sent = 0;
      while (sent < 8) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_message(n);
        sent += n;
      end
    end

    // over-long message: fills to the maximum length, then one byte past it
    write_mode(ModeSpare);
    send_message(255 - 64 + 1);

    // closing stretch with no idling on either side
    idle_en = 1'b0;
    write_mode(ModeP32);
    sent = 0;
    while (sent < 10) begin
      n = $urandom_range(1, 8);
      send_message(n);
      sent += n;
    end

    settle();
    if (errors == 0) begin
      $display("rs_gf256_systematic_encoder_core_tb: PASS");
    end else begin
      $display("rs_gf256_systematic_encoder_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("rs_gf256_systematic_encoder_core_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
